@@ hdl/grfs_pkg.sv @@
// Shared types, codes and constants for the grid rectangle fill store.
// Used by the RAM, the fill walker and the top level; depends on nothing.
package grfs_pkg;

  localparam int COORD_BITS   = 7;
  localparam int CFG_BITS     = 8;
  localparam int DATA_BITS    = 30;
  localparam int CFG_IDX_BITS = 2;
  localparam int LIMIT_BITS   = 11;

  localparam int DEF_MAX_ROWS   = 128;
  localparam int DEF_MAX_COLS   = 128;
  localparam int DEF_VALUE_BITS = 30;

  localparam logic [CFG_BITS-1:0]     CFG_RESET = 8'd128;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLS  = 2'd1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_FILL = 2'd1,
    REQ_READ = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_RESP
  } state_t;

  typedef struct packed {
    coord_t top;
    coord_t left;
    coord_t bottom;
    coord_t right;
  } walk_req_t;

  function automatic int addr_bits(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic logic in_range(coord_t pos, logic [CFG_BITS-1:0] lim,
                                    logic [LIMIT_BITS-1:0] max_lim);
    logic [LIMIT_BITS-1:0] p;
    p = LIMIT_BITS'(pos);
    return (p < LIMIT_BITS'(lim)) && (p < max_lim);
  endfunction

endpackage

@@ hdl/grfs_ram.sv @@
// Generic single-port RAM with registered read data.
// Depends on grfs_pkg for the address width helper.
module grfs_ram import grfs_pkg::*; #(
  parameter int WIDTH = DEF_VALUE_BITS,
  parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic                          re,
  input  logic [addr_bits(DEPTH)-1:0]   addr,
  input  logic [WIDTH-1:0]              wdata,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ hdl/grfs_walk.sv @@
// Rectangle walker: row and column position with one shared address adder.
// Steps one cell a cycle while step is high, row by row; depends on grfs_pkg.
module grfs_walk import grfs_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int DEPTH    = DEF_MAX_ROWS * DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          start,
  input  logic                          step,
  input  walk_req_t                     req,
  input  logic [addr_bits(DEPTH)-1:0]   start_addr,
  output logic [addr_bits(DEPTH)-1:0]   addr,
  output logic                          last
);

  localparam int AW = addr_bits(DEPTH);
  localparam logic [AW-1:0] STRIDE = AW'(MAX_COLS);

  coord_t          row;
  coord_t          col;
  coord_t          left;
  coord_t          bottom;
  coord_t          right;
  logic [AW-1:0]   row_start;
  logic            row_end;
  logic [AW-1:0]   add_a;
  logic [AW-1:0]   add_b;
  logic [AW-1:0]   sum;

  assign row_end = (col == right);
  assign last    = row_end && (row == bottom);

  // one adder: next column, or start of the next row
  assign add_a = row_end ? row_start : addr;
  assign add_b = row_end ? STRIDE : AW'(1);
  assign sum   = add_a + add_b;

  always_ff @(posedge clk) begin
    if (start) begin
      row       <= req.top;
      col       <= req.left;
      left      <= req.left;
      bottom    <= req.bottom;
      right     <= req.right;
      addr      <= start_addr;
      row_start <= start_addr;
    end else if (step && !last) begin
      addr <= sum;
      if (row_end) begin
        row       <= row + 1'b1;
        col       <= left;
        row_start <= sum;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

@@ hdl/grid_rectangle_fill_store.sv @@
// Grid rectangle fill store: load, fill rectangle and read one cell.
// Sequencer, grid registers and output register; uses grfs_pkg, grfs_ram, grfs_walk.
//
// Input channel (in_valid / in_stall): one request per item, chosen by req_type.
// Output channel (out_valid / out_stall): one item per read request only.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 sets
// rows in use, index 1 columns in use; other indexes are dropped.
// Load: the next item may follow at once.
// Fill: after the accept, the walker writes one cell of the rectangle per cycle, up
// to MAX_ROWS * MAX_COLS cells; the walker's single address adder and the one
// RAM write port set this rate. in_stall stays high while it runs.
// Read: the RAM read is issued at accept into the RAM's registered read data; the
// result then enters the output register once that is free, and out_valid rises in
// the cycle in which the input can take the next item.
// A waiting result is held while out_stall is high; a further read then waits
// with in_stall high until the output register frees. Loads and fills pass.
// Reset: rows and columns in use return to 128, the output register empties.
// The grid is not cleared; a cell reads as written by load or fill.
module grid_rectangle_fill_store import grfs_pkg::*; #(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              req_type,
  input  logic [COORD_BITS-1:0]   top_row,
  input  logic [COORD_BITS-1:0]   left_col,
  input  logic [COORD_BITS-1:0]   bottom_row,
  input  logic [COORD_BITS-1:0]   right_col,
  input  logic [DATA_BITS-1:0]    data_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DATA_BITS-1:0]    read_value,
  output logic                    bad_address,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = addr_bits(DEPTH);
  localparam logic [AW-1:0]         STRIDE   = AW'(MAX_COLS);
  localparam logic [LIMIT_BITS-1:0] ROW_LIM  = LIMIT_BITS'(MAX_ROWS);
  localparam logic [LIMIT_BITS-1:0] COL_LIM  = LIMIT_BITS'(MAX_COLS);

  state_t                state;
  state_t                state_next;
  logic [CFG_BITS-1:0]   rows_cfg;
  logic [CFG_BITS-1:0]   cols_cfg;
  logic [VALUE_BITS-1:0] fill_val;
  logic                  rd_bad;

  logic                  accept;
  logic                  cell_ok;
  logic                  fill_ok;
  logic [AW-1:0]         port_addr;
  logic [63:0]           in_wide;
  logic [63:0]           rd_wide;
  logic [VALUE_BITS-1:0] in_val;

  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_addr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic                  walk_start;
  logic                  walk_step;
  walk_req_t             walk_req;
  logic [AW-1:0]         walk_addr;
  logic                  walk_last;
  logic                  out_load;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = in_valid && !in_stall;

  assign cell_ok = in_range(top_row, rows_cfg, ROW_LIM) && in_range(left_col, cols_cfg, COL_LIM);
  assign fill_ok = (top_row <= bottom_row) && (left_col <= right_col) &&
                   in_range(bottom_row, rows_cfg, ROW_LIM) &&
                   in_range(right_col, cols_cfg, COL_LIM);

  assign port_addr = AW'(top_row) * STRIDE + AW'(left_col);
  assign in_wide   = 64'(data_value);
  assign in_val    = in_wide[VALUE_BITS-1:0];
  assign rd_wide   = 64'(ram_rdata);

  assign walk_req  = '{top: top_row, left: left_col, bottom: bottom_row, right: right_col};
  assign ram_addr  = (state == ST_FILL) ? walk_addr : port_addr;
  assign ram_wdata = (state == ST_FILL) ? fill_val : in_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    walk_start = 1'b0;
    walk_step  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type)
            REQ_LOAD: begin
              ram_we = cell_ok;
            end
            REQ_FILL: begin
              if (fill_ok) begin
                walk_start = 1'b1;
                state_next = ST_FILL;
              end
            end
            REQ_READ: begin
              ram_re     = cell_ok;
              state_next = ST_RESP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        walk_step = 1'b1;
        if (walk_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= CFG_RESET;
      cols_cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ROWS) begin
        rows_cfg <= cfg_data;
      end else if (cfg_index == CFG_COLS) begin
        cols_cfg <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (walk_start) begin
      fill_val <= in_val;
    end
    if (accept) begin
      rd_bad <= !cell_ok;
    end
    if (out_load) begin
      read_value  <= rd_bad ? '0 : rd_wide[DATA_BITS-1:0];
      bad_address <= rd_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  grfs_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  grfs_walk #(
    .MAX_COLS (MAX_COLS),
    .DEPTH    (DEPTH)
  ) u_walk (
    .clk        (clk),
    .start      (walk_start),
    .step       (walk_step),
    .req        (walk_req),
    .start_addr (port_addr),
    .addr       (walk_addr),
    .last       (walk_last)
  );

  a_out_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESP)
    else $error("output item appeared without a read response");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_address |-> read_value == '0)
    else $error("bad address item carries a non-zero value");

  a_fill_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL && walk_last |=> state == ST_IDLE)
    else $error("fill did not stop at the last cell");

  a_fill_addr: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> 32'(walk_addr) < 32'(DEPTH))
    else $error("fill address beyond the grid store");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for grid_rectangle_fill_store: loads, rectangle fills and reads
// under several grid settings, each read checked against a cycle-free prediction of the grid.
// Depends on grfs_pkg and the grid_rectangle_fill_store RTL only.
`timescale 1ns / 100ps

module tb_top;
  import grfs_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 100000;
  localparam int GRID_SIDE = 128;

  typedef struct packed {
    logic [1:0]           req;
    coord_t               top;
    coord_t               left;
    coord_t               bottom;
    coord_t               right;
    logic [DATA_BITS-1:0] data;
  } grid_req_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] value;
    logic                 bad;
  } read_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  coord_t top_row = '0;
  coord_t left_col = '0;
  coord_t bottom_row = '0;
  coord_t right_col = '0;
  logic [DATA_BITS-1:0] data_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_BITS-1:0] read_value;
  logic bad_address;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  // grid prediction
  logic [DATA_BITS-1:0] cell_store [GRID_SIDE*GRID_SIDE];
  logic [CFG_BITS-1:0] rows_cfg = CFG_RESET;
  logic [CFG_BITS-1:0] cols_cfg = CFG_RESET;
  int last_fill_cells = 0;

  grid_req_t pending_requests[$];
  read_result_t expected_reads[$];
  grid_req_t next_req;

  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_span = 0;
  int idle_cycles = 0;
  int errors = 0;
  int accepted_items = 0;
  int reads_checked = 0;
  int fills_done = 0;
  int cfg_writes = 0;

  always #10 clk = ~clk;

  grid_rectangle_fill_store dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .top_row     (top_row),
    .left_col    (left_col),
    .bottom_row  (bottom_row),
    .right_col   (right_col),
    .data_value  (data_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .bad_address (bad_address),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  function automatic int grid_limit(logic [CFG_BITS-1:0] v);
    return (v > CFG_BITS'(GRID_SIDE)) ? GRID_SIDE : int'(v);
  endfunction

  task automatic apply_request(grid_req_t it);
    int er;
    int ec;
    int r;
    int c;
    read_result_t res;
    er = grid_limit(rows_cfg);
    ec = grid_limit(cols_cfg);
    last_fill_cells = 0;
    case (it.req)
      REQ_LOAD: begin
        if (it.top < er && it.left < ec) cell_store[{it.top, it.left}] = it.data;
      end
      REQ_FILL: begin
        last_fill_cells = 1;
        if (!(it.top > it.bottom || it.left > it.right || it.bottom >= er || it.right >= ec))
        begin
          for (r = it.top; r <= it.bottom; r++)
            for (c = it.left; c <= it.right; c++)
              cell_store[r * GRID_SIDE + c] = it.data;
          last_fill_cells = (it.bottom - it.top + 1) * (it.right - it.left + 1);
          fills_done++;
        end
      end
      REQ_READ: begin
        if (it.top < er && it.left < ec) begin
          res.value = cell_store[{it.top, it.left}];
          res.bad = 1'b0;
        end else begin
          res.value = '0;
          res.bad = 1'b1;
        end
        expected_reads.push_back(res);
      end
      default: ;
    endcase
  endtask

  // driver: bursts of items with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request({req_type, top_row, left_col, bottom_row, right_col, data_value});
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_req = pending_requests.pop_front();
          {req_type, top_row, left_col, bottom_row, right_col, data_value} <= next_req;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each read item, stall on a pattern of its own
  always @(posedge clk) begin
    read_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h/%b", $time,
                   read_value, bad_address);
          errors++;
        end else begin
          want = expected_reads.pop_front();
          reads_checked++;
          if (read_value !== want.value) begin
            $display("%0t: read_value mismatch, expected %h, actual %h", $time,
                     want.value, read_value);
            errors++;
          end
          if (bad_address !== want.bad) begin
            $display("%0t: bad_address mismatch, expected %b, actual %b", $time,
                     want.bad, bad_address);
            errors++;
          end
        end
      end
      if (stall_span == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_span <= $urandom_range(16, 80);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 1);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) || rst)
    begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [DATA_BITS-1:0] random_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return DATA_BITS'($urandom);
    endcase
  endfunction

  function automatic grid_req_t make_req(logic [1:0] req, int t, int l, int b, int r,
                                         logic [DATA_BITS-1:0] d);
    grid_req_t it;
    it.req = req;
    it.top = coord_t'(t);
    it.left = coord_t'(l);
    it.bottom = coord_t'(b);
    it.right = coord_t'(r);
    it.data = d;
    return it;
  endfunction

  function automatic grid_req_t random_request(int er, int ec);
    grid_req_t it;
    int kind;
    int span;
    it.req = 2'($urandom);
    it.top = coord_t'($urandom);
    it.left = coord_t'($urandom);
    it.bottom = coord_t'($urandom);
    it.right = coord_t'($urandom);
    it.data = random_value();
    if (er == 0 || ec == 0) return it;
    kind = $urandom_range(0, 99);
    it.top = coord_t'($urandom_range(er - 1, 0));
    it.left = coord_t'($urandom_range(ec - 1, 0));
    if (kind < 40) begin
      it.req = REQ_READ;
    end else if (kind < 65) begin
      it.req = REQ_LOAD;
    end else if (kind < 90) begin
      it.req = REQ_FILL;
      if ($urandom_range(0, 29) == 0) begin
        it.top = '0;
        it.left = '0;
        it.bottom = coord_t'(er - 1);
        it.right = coord_t'(ec - 1);
      end else begin
        span = it.top + $urandom_range(0, 7);
        it.bottom = coord_t'((span < er) ? span : er - 1);
        span = it.left + $urandom_range(0, 7);
        it.right = coord_t'((span < ec) ? span : ec - 1);
      end
    end else begin
      it.req = 2'($urandom_range(0, 2));
      case ($urandom_range(0, 2))
        0: it.req = REQ_SPARE;
        1: begin
          it.req = REQ_FILL;
          it.bottom = coord_t'($urandom_range(0, 126));
          it.top = coord_t'($urandom_range(127, it.bottom + 1));
        end
        default: begin
          if (er < GRID_SIDE) begin
            if (it.req == REQ_FILL) it.bottom = coord_t'($urandom_range(127, er));
            else it.top = coord_t'($urandom_range(127, er));
          end else if (ec < GRID_SIDE) begin
            if (it.req == REQ_FILL) it.right = coord_t'($urandom_range(127, ec));
            else it.left = coord_t'($urandom_range(127, ec));
          end else begin
            it.req = REQ_FILL;
            it.right = coord_t'($urandom_range(0, 126));
            it.left = coord_t'($urandom_range(127, it.right + 1));
          end
        end
      endcase
    end
    return it;
  endfunction

  task automatic queue_random(int count);
    int i;
    @(negedge clk);
    for (i = 0; i < count; i++)
      pending_requests.push_back(random_request(grid_limit(rows_cfg), grid_limit(cols_cfg)));
  endtask

  // hold until every item is taken and every read has returned, then let a fill finish
  task automatic settle();
    @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_reads.size() != 0)
      @(negedge clk);
    repeat (last_fill_cells + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROWS) rows_cfg = val;
    else cols_cfg = val;
    cfg_writes++;
  endtask

  task automatic set_grid(logic [CFG_BITS-1:0] rows, logic [CFG_BITS-1:0] cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    pending_requests.push_back(make_req(REQ_FILL, 0, 0, 127, 127, '1));
    pending_requests.push_back(make_req(REQ_READ, 0, 0, 0, 0, '0));
    pending_requests.push_back(make_req(REQ_READ, 127, 127, 0, 0, '0));
    pending_requests.push_back(make_req(REQ_LOAD, 0, 0, 0, 0, '0));
    pending_requests.push_back(make_req(REQ_LOAD, 127, 127, 0, 0, 30'h15555555));
    pending_requests.push_back(make_req(REQ_READ, 0, 0, 0, 0, '0));
    pending_requests.push_back(make_req(REQ_READ, 127, 127, 0, 0, '0));
    pending_requests.push_back(make_req(REQ_FILL, 5, 6, 5, 6, 30'h2AAAAAAA));
    pending_requests.push_back(make_req(REQ_READ, 5, 6, 0, 0, '0));
    pending_requests.push_back(make_req(REQ_FILL, 10, 0, 9, 5, '0));
    pending_requests.push_back(make_req(REQ_FILL, 0, 10, 5, 9, '0));
    pending_requests.push_back(make_req(REQ_READ, 9, 3, 0, 0, '0));
    pending_requests.push_back(make_req(REQ_SPARE, 127, 127, 127, 127, '1));
    pending_requests.push_back(make_req(REQ_FILL, 0, 120, 3, 127, 30'h0F0F0F0F));
    pending_requests.push_back(make_req(REQ_READ, 3, 127, 0, 0, '0));
    pending_requests.push_back(make_req(REQ_READ, 2, 119, 0, 0, '0));
    pending_requests.push_back(make_req(REQ_READ, 0, 120, 0, 0, '0));
    pending_requests.push_back(make_req(REQ_FILL, 126, 0, 127, 1, '0));
    pending_requests.push_back(make_req(REQ_READ, 127, 0, 0, 0, '0));
    settle();

    set_grid(8'd255, 8'd200);
    queue_random(20);
    settle();
    set_grid(8'd0, 8'd77);
    queue_random(8);
    settle();
    set_grid(8'd1, 8'd1);
    queue_random(10);
    settle();
    set_grid(CFG_BITS'($urandom_range(2, 24)), CFG_BITS'($urandom_range(2, 24)));
    queue_random(15);
    settle();
    queue_random(15);
    settle();
    set_grid(8'd128, 8'd1);
    queue_random(8);
    settle();
    set_grid(8'd1, 8'd128);
    queue_random(8);
    settle();
    set_grid(CFG_BITS'($urandom_range(100, 127)), 8'd128);
    queue_random(16);
    settle();

    $display("tb_top: %0d items accepted, %0d fills applied, %0d reads checked",
             accepted_items, fills_done, reads_checked);
    $display("tb_top: %0d register writes over eight grid settings, %0d errors",
             cfg_writes, errors);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
